// ===== src/psd_pkg.sv =====
// ============================================================================
// psd_pkg
// Shared constants and types for the point to segment closest distance block.
// ============================================================================
`default_nettype none

package psd_pkg;

    // Default coordinate width (signed Q12.12) and fraction width of t.
    localparam int COORD_WIDTH_DEF = 24;
    localparam int T_FRAC_BITS_DEF = 24;

    // Where the closest point lies on the segment.
    typedef enum logic [1:0] {
        REGION_DEGEN    = 2'd0,
        REGION_START    = 2'd1,
        REGION_END      = 2'd2,
        REGION_INTERIOR = 2'd3
    } region_t;

endpackage

`default_nettype wire

// ===== src/point_segment_closest_distance.sv =====
// ============================================================================
// point_segment_closest_distance
// Path from an accepted input word to its result word: psd_front, psd_div,
// psd_back and psd_sqrt, each built of registered stages.
// Throughput: one word per cycle; the per-bit divider and square root stages
// set the depth, each stage stalls only when it is full and cannot pass on.
// Reset clears all valid bits at once; data registers are not reset.
// ============================================================================
`default_nettype none

module point_segment_closest_distance
    import psd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    // seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
    // query_x, query_y, query_z
    input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    // near_x, near_y, near_z, dist_squared, dist_res
    output logic [((6*COORD_WIDTH+3+7)/8)*8-1:0]    m_tdata,
    // region
    output logic [1:0] m_tuser
);

    localparam int C      = COORD_WIDTH;
    localparam int W      = 2 * C + 2;
    localparam int SIDE1  = 9 * C + 6;
    localparam int SIDE2  = 3 * C + 2;
    localparam int OUT_W  = ((6 * C + 3 + 7) / 8) * 8;

    logic           f_valid, f_ready;
    logic [W-1:0]   f_rem, f_den;
    logic [SIDE1-1:0] f_side;
    logic           d_valid, d_ready;
    logic [T_FRAC_BITS-1:0] d_quo;
    logic [SIDE1-1:0] d_side;
    logic           b_valid, b_ready;
    logic [3*C-1:0] b_q;
    logic [W-1:0]   b_dsq;
    region_t        b_region;
    logic [C:0]     r_root;
    logic [W-1:0]   r_dsq;
    logic [SIDE2-1:0] r_side;

    psd_front #(.C(C)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_a      (s_tdata[3*C-1:0]),
        .in_b      (s_tdata[6*C-1:3*C]),
        .in_p      (s_tdata[9*C-1:6*C]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_rem   (f_rem),
        .out_den   (f_den),
        .out_side  (f_side)
    );

    psd_div #(.W(W), .T(T_FRAC_BITS), .SW(SIDE1)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_rem    (f_rem),
        .in_den    (f_den),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    psd_back #(.C(C), .T(T_FRAC_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d_valid),
        .in_ready   (d_ready),
        .in_quo     (d_quo),
        .in_side    (d_side),
        .out_valid  (b_valid),
        .out_ready  (b_ready),
        .out_q      (b_q),
        .out_dsq    (b_dsq),
        .out_region (b_region)
    );

    psd_sqrt #(.R(C + 1), .SW(SIDE2)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_val    (b_dsq),
        .in_side   ({b_region, b_q}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_root  (r_root),
        .out_val   (r_dsq),
        .out_side  (r_side)
    );

    assign m_tdata = OUT_W'({r_root, r_dsq, r_side[3*C-1:0]});
    assign m_tuser = r_side[3*C+1:3*C];

endmodule

`default_nettype wire

// ===== src/psd_front.sv =====
// ============================================================================
// psd_front
// Three stages: edge vectors, dot products, then squared length, projection
// and region classification.
// ============================================================================
`default_nettype none

module psd_front
    import psd_pkg::*;
#(
    parameter int C = COORD_WIDTH_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [3*C-1:0]        in_a,
    input  wire logic [3*C-1:0]        in_b,
    input  wire logic [3*C-1:0]        in_p,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [2*C+1:0]             out_rem,
    output logic [2*C+1:0]             out_den,
    output logic [9*C+5:0]             out_side
);

    localparam int D  = C + 1;
    localparam int PW = 2 * C + 2;
    localparam int DW = 2 * C + 3;
    localparam int NS = 3;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] rdy;
    logic [NS-1:0] vin;

    logic [3*C-1:0] a1_reg, p1_reg, a2_reg, p2_reg, a3_reg, p3_reg;
    logic [3*D-1:0] d1_reg, e1_reg, d2_reg, d3_reg;
    logic [3*PW-1:0] dd2_reg, de2_reg;
    logic [3*D-1:0] d1_next, e1_next;
    logic [3*PW-1:0] dd2_next, de2_next;
    logic [PW-1:0] s3_reg, rem3_reg;
    logic eq3_reg;
    region_t region3_reg;

    logic [PW-1:0] s_sum;
    logic signed [DW-1:0] dot_sum;
    region_t region_next;
    logic eq_next;
    logic [PW-1:0] rem_next;

    assign vin = {valid_reg[NS-2:0], in_valid};

    always_comb
    begin
        rdy[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    genvar i;
    generate
        for (i = 0; i < 3; i++)
        begin : g_axis
            logic signed [D-1:0] ax, bx, px, dx, ex;
            logic signed [PW-1:0] ddx, dex;
            assign ax = $signed({in_a[i*C+C-1], in_a[i*C +: C]});
            assign bx = $signed({in_b[i*C+C-1], in_b[i*C +: C]});
            assign px = $signed({in_p[i*C+C-1], in_p[i*C +: C]});
            assign d1_next[i*D +: D] = bx - ax;
            assign e1_next[i*D +: D] = px - ax;
            assign dx = $signed(d1_reg[i*D +: D]);
            assign ex = $signed(e1_reg[i*D +: D]);
            assign ddx = dx * dx;
            assign dex = dx * ex;
            assign dd2_next[i*PW +: PW] = ddx;
            assign de2_next[i*PW +: PW] = dex;
        end
    endgenerate

    always_comb
    begin
        s_sum = dd2_reg[0 +: PW] + dd2_reg[PW +: PW] + dd2_reg[2*PW +: PW];
        dot_sum = DW'($signed(de2_reg[0 +: PW])) + DW'($signed(de2_reg[PW +: PW]))
                + DW'($signed(de2_reg[2*PW +: PW]));
        eq_next = (dot_sum == $signed({1'b0, s_sum}));
        if (s_sum == '0)
        begin
            region_next = REGION_DEGEN;
        end
        else if (dot_sum < 0)
        begin
            region_next = REGION_START;
        end
        else if (dot_sum > $signed({1'b0, s_sum}))
        begin
            region_next = REGION_END;
        end
        else
        begin
            region_next = REGION_INTERIOR;
        end
        // Only a proper fraction is divided; every other case starts from zero.
        rem_next = (region_next == REGION_INTERIOR && !eq_next) ? dot_sum[PW-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (valid_reg & ~rdy) | (vin & rdy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (vin[0] && rdy[0])
        begin
            a1_reg <= in_a;
            p1_reg <= in_p;
            d1_reg <= d1_next;
            e1_reg <= e1_next;
        end
        if (vin[1] && rdy[1])
        begin
            a2_reg  <= a1_reg;
            p2_reg  <= p1_reg;
            d2_reg  <= d1_reg;
            dd2_reg <= dd2_next;
            de2_reg <= de2_next;
        end
        if (vin[2] && rdy[2])
        begin
            a3_reg      <= a2_reg;
            p3_reg      <= p2_reg;
            d3_reg      <= d2_reg;
            s3_reg      <= s_sum;
            rem3_reg    <= rem_next;
            eq3_reg     <= eq_next;
            region3_reg <= region_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NS-1];
    assign out_rem   = rem3_reg;
    assign out_den   = s3_reg;
    assign out_side  = {region3_reg, eq3_reg, d3_reg, p3_reg, a3_reg};

endmodule

`default_nettype wire

// ===== src/psd_div.sv =====
// ============================================================================
// psd_div
// Pipelined restoring divider: one quotient bit per stage, giving the
// fraction rem * 2^T / den for rem below den.
// ============================================================================
`default_nettype none

module psd_div
    import psd_pkg::*;
#(
    parameter int W  = 2 * COORD_WIDTH_DEF + 2,
    parameter int T  = T_FRAC_BITS_DEF,
    parameter int SW = 9 * COORD_WIDTH_DEF + 6
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [W-1:0]  in_rem,
    input  wire logic [W-1:0]  in_den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [T-1:0]       out_quo,
    output logic [SW-1:0]      out_side
);

    logic [T-1:0] valid_reg;
    logic [T-1:0] rdy;
    logic [T-1:0] vin;

    logic [W-1:0]  rem_reg  [T];
    logic [W-1:0]  den_reg  [T];
    logic [T-1:0]  quo_reg  [T];
    logic [SW-1:0] side_reg [T];
    logic [W-1:0]  rem_src  [T];
    logic [W-1:0]  den_src  [T];
    logic [T-1:0]  quo_src  [T];
    logic [SW-1:0] side_src [T];

    assign vin = {valid_reg[T-2:0], in_valid};

    always_comb
    begin
        rdy[T-1] = !valid_reg[T-1] || out_ready;
        for (int k = T - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    genvar k;
    generate
        for (k = 0; k < T; k++)
        begin : g_stage
            logic [W:0]   shl;
            logic [W:0]   diff;
            logic         ge;
            logic [W-1:0] rem_next;
            logic [T-1:0] quo_next;

            if (k == 0)
            begin : g_first
                assign rem_src[k]  = in_rem;
                assign den_src[k]  = in_den;
                assign quo_src[k]  = '0;
                assign side_src[k] = in_side;
            end
            else
            begin : g_next
                assign rem_src[k]  = rem_reg[k-1];
                assign den_src[k]  = den_reg[k-1];
                assign quo_src[k]  = quo_reg[k-1];
                assign side_src[k] = side_reg[k-1];
            end

            assign shl      = {rem_src[k], 1'b0};
            assign diff     = shl - {1'b0, den_src[k]};
            assign ge       = (shl >= {1'b0, den_src[k]});
            assign rem_next = ge ? diff[W-1:0] : shl[W-1:0];
            assign quo_next = {quo_src[k][T-2:0], ge};

            always_ff @(posedge clk)
            begin
                if (vin[k] && rdy[k])
                begin
                    rem_reg[k]  <= rem_next;
                    den_reg[k]  <= den_src[k];
                    quo_reg[k]  <= quo_next;
                    side_reg[k] <= side_src[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (valid_reg & ~rdy) | (vin & rdy);
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[T-1];
    assign out_quo   = quo_reg[T-1];
    assign out_side  = side_reg[T-1];

`ifndef SYNTHESIS
    // The partial remainder of a proper division never reaches the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[T-1] && den_reg[T-1] != '0 |-> rem_reg[T-1] < den_reg[T-1])
        else $error("psd_div: remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== src/psd_back.sv =====
// ============================================================================
// psd_back
// Four stages: offset along the segment, closest point, per-axis squared
// error, and the squared distance.
// ============================================================================
`default_nettype none

module psd_back
    import psd_pkg::*;
#(
    parameter int C = COORD_WIDTH_DEF,
    parameter int T = T_FRAC_BITS_DEF
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [T-1:0]     in_quo,
    input  wire logic [9*C+5:0]   in_side,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [3*C-1:0]        out_q,
    output logic [2*C+1:0]        out_dsq,
    output region_t               out_region
);

    localparam int D  = C + 1;
    localparam int MW = C + T + 2;
    localparam int PW = 2 * C + 2;
    localparam int NS = 4;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] rdy;
    logic [NS-1:0] vin;

    logic [3*C-1:0] in_a, in_p;
    logic [3*D-1:0] in_d;
    logic           in_eq;
    region_t        in_region;
    logic [T:0]     t_val;

    logic [3*MW-1:0] prod1_reg, prod1_next;
    logic [3*C-1:0]  a1_reg, p1_reg, q2_reg, p2_reg, q3_reg, q4_reg;
    logic [3*D-1:0]  d1_reg;
    logic [3*C-1:0]  q2_next;
    logic [3*PW-1:0] rr3_reg, rr3_next;
    logic [PW-1:0]   dsq4_reg;
    region_t         region1_reg, region2_reg, region3_reg, region4_reg;

    assign in_a      = in_side[3*C-1:0];
    assign in_p      = in_side[6*C-1:3*C];
    assign in_d      = in_side[9*C+2:6*C];
    assign in_eq     = in_side[9*C+3];
    assign in_region = region_t'(in_side[9*C+5:9*C+4]);
    // A dot product equal to the squared length means t is exactly one.
    assign t_val     = in_eq ? ((T+1)'(1) << T) : {1'b0, in_quo};

    assign vin = {valid_reg[NS-2:0], in_valid};

    always_comb
    begin
        rdy[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    genvar i;
    generate
        for (i = 0; i < 3; i++)
        begin : g_axis
            logic signed [D-1:0] dx, d1x, qd, px, rx;
            logic [D-1:0]        mag, m;
            logic signed [D-1:0] ax;
            logic signed [PW-1:0] rrx;

            assign dx  = $signed(in_d[i*D +: D]);
            assign mag = dx[D-1] ? D'(-dx) : D'(dx);
            assign prod1_next[i*MW +: MW] = MW'(mag) * MW'(t_val);

            assign d1x = $signed(d1_reg[i*D +: D]);
            assign ax  = $signed({a1_reg[i*C+C-1], a1_reg[i*C +: C]});
            assign m   = prod1_reg[i*MW+T +: D];

            always_comb
            begin
                case (region1_reg)
                    REGION_INTERIOR: qd = d1x[D-1] ? ax - $signed(m) : ax + $signed(m);
                    REGION_END:      qd = ax + d1x;
                    default:         qd = ax;
                endcase
            end
            assign q2_next[i*C +: C] = qd[C-1:0];

            assign px  = $signed({p2_reg[i*C+C-1], p2_reg[i*C +: C]});
            assign rx  = $signed({q2_reg[i*C+C-1], q2_reg[i*C +: C]}) - px;
            assign rrx = rx * rx;
            assign rr3_next[i*PW +: PW] = rrx;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (valid_reg & ~rdy) | (vin & rdy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (vin[0] && rdy[0])
        begin
            prod1_reg   <= prod1_next;
            a1_reg      <= in_a;
            p1_reg      <= in_p;
            d1_reg      <= in_d;
            region1_reg <= in_region;
        end
        if (vin[1] && rdy[1])
        begin
            q2_reg      <= q2_next;
            p2_reg      <= p1_reg;
            region2_reg <= region1_reg;
        end
        if (vin[2] && rdy[2])
        begin
            rr3_reg     <= rr3_next;
            q3_reg      <= q2_reg;
            region3_reg <= region2_reg;
        end
        if (vin[3] && rdy[3])
        begin
            dsq4_reg    <= rr3_reg[0 +: PW] + rr3_reg[PW +: PW] + rr3_reg[2*PW +: PW];
            q4_reg      <= q3_reg;
            region4_reg <= region3_reg;
        end
    end

    assign in_ready   = rdy[0];
    assign out_valid  = valid_reg[NS-1];
    assign out_q      = q4_reg;
    assign out_dsq    = dsq4_reg;
    assign out_region = region4_reg;

endmodule

`default_nettype wire

// ===== src/psd_sqrt.sv =====
// ============================================================================
// psd_sqrt
// Pipelined integer square root: one root bit per stage, truncated.
// ============================================================================
`default_nettype none

module psd_sqrt
    import psd_pkg::*;
#(
    parameter int R  = COORD_WIDTH_DEF + 1,
    parameter int SW = 3 * COORD_WIDTH_DEF + 2
)(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [2*R-1:0]  in_val,
    input  wire logic [SW-1:0]   in_side,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [R-1:0]         out_root,
    output logic [2*R-1:0]       out_val,
    output logic [SW-1:0]        out_side
);

    localparam int W = 2 * R;

    logic [R-1:0] valid_reg;
    logic [R-1:0] rdy;
    logic [R-1:0] vin;

    logic [W-1:0]  v_reg    [R];
    logic [W-1:0]  r_reg    [R];
    logic [W-1:0]  val_reg  [R];
    logic [SW-1:0] side_reg [R];
    logic [W-1:0]  v_src    [R];
    logic [W-1:0]  r_src    [R];
    logic [W-1:0]  val_src  [R];
    logic [SW-1:0] side_src [R];

    assign vin = {valid_reg[R-2:0], in_valid};

    always_comb
    begin
        rdy[R-1] = !valid_reg[R-1] || out_ready;
        for (int k = R - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    genvar k;
    generate
        for (k = 0; k < R; k++)
        begin : g_stage
            localparam logic [W-1:0] BITV = W'(1) << (2 * (R - 1 - k));
            logic [W:0]   trial;
            logic [W:0]   diff;
            logic         ge;
            logic [W-1:0] v_next;
            logic [W-1:0] r_next;

            if (k == 0)
            begin : g_first
                assign v_src[k]    = in_val;
                assign r_src[k]    = '0;
                assign val_src[k]  = in_val;
                assign side_src[k] = in_side;
            end
            else
            begin : g_next
                assign v_src[k]    = v_reg[k-1];
                assign r_src[k]    = r_reg[k-1];
                assign val_src[k]  = val_reg[k-1];
                assign side_src[k] = side_reg[k-1];
            end

            assign trial  = {1'b0, r_src[k]} + {1'b0, BITV};
            assign diff   = {1'b0, v_src[k]} - trial;
            assign ge     = ({1'b0, v_src[k]} >= trial);
            assign v_next = ge ? diff[W-1:0] : v_src[k];
            assign r_next = ge ? ((r_src[k] >> 1) + BITV) : (r_src[k] >> 1);

            always_ff @(posedge clk)
            begin
                if (vin[k] && rdy[k])
                begin
                    v_reg[k]    <= v_next;
                    r_reg[k]    <= r_next;
                    val_reg[k]  <= val_src[k];
                    side_reg[k] <= side_src[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (valid_reg & ~rdy) | (vin & rdy);
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[R-1];
    assign out_root  = r_reg[R-1][R-1:0];
    assign out_val   = val_reg[R-1];
    assign out_side  = side_reg[R-1];

`ifndef SYNTHESIS
    // The root is the floor: its square fits and the next one does not.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[R-1] |-> ((W+2)'(out_root) * (W+2)'(out_root) <= (W+2)'(out_val)))
        else $error("psd_sqrt: root too large");
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[R-1] |-> (((W+2)'(out_root) + (W+2)'(1)) * ((W+2)'(out_root) + (W+2)'(1))
                            > (W+2)'(out_val)))
        else $error("psd_sqrt: root too small");
    // Every bit of the input must have been worked off into the root.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[R-1] |-> v_reg[R-1] <= (W'(out_root) << 1))
        else $error("psd_sqrt: remainder out of range");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_point_segment_closest_distance.sv =====
// ----------------------------------------------------------------------------
// Point to segment closest distance testbench
// Streams segment and query words through the block under random idling on
// both sides and checks each result word against an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_segment_closest_distance
    import psd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 24;
    localparam int TF = 24;
    localparam int IN_W = ((9*CW+7)/8)*8;
    localparam int OUT_W = ((6*CW+3+7)/8)*8;
    localparam int LATENCY = 3 + TF + 4 + CW + 1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CW-1:0]   near_x;
        logic [CW-1:0]   near_y;
        logic [CW-1:0]   near_z;
        logic [2*CW+1:0] dsq;
        logic [CW:0]     droot;
        region_t         region;
    } closest_t;

    class closest_scoreboard;
        closest_t pending[$];
        int       mismatches;

        function logic [63:0] root_floor(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_segment(logic [IN_W-1:0] w);
            longint   a[3];
            longint   b[3];
            longint   p[3];
            longint   d[3];
            longint   q[3];
            longint   pr;
            longint   r;
            logic [63:0] s;
            logic [63:0] pos;
            logic [63:0] neg;
            logic [63:0] dsq;
            logic [63:0] dot;
            logic [63:0] t;
            logic [63:0] rem;
            logic [63:0] m;
            logic [63:0] mag;
            logic [63:0] root;
            closest_t c;
            s = 0; pos = 0; neg = 0; dsq = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = longint'($signed(w[i*CW +: CW]));
                b[i] = longint'($signed(w[(3+i)*CW +: CW]));
                p[i] = longint'($signed(w[(6+i)*CW +: CW]));
                d[i] = b[i] - a[i];
                s = s + d[i] * d[i];
                pr = d[i] * (p[i] - a[i]);
                if (pr >= 0)
                    pos = pos + pr;
                else
                    neg = neg - pr;
            end
            if (s == 0)
            begin
                c.region = REGION_DEGEN;
                q = a;
            end
            else if (neg > pos)
            begin
                c.region = REGION_START;
                q = a;
            end
            else if (pos - neg > s)
            begin
                c.region = REGION_END;
                q = b;
            end
            else
            begin
                c.region = REGION_INTERIOR;
                dot = pos - neg;
                if (dot == s)
                    t = 64'd1 << TF;
                else
                begin
                    // Restoring division for the fraction of dot over s.
                    rem = dot;
                    t = 0;
                    for (int k = 0; k < TF; k++)
                    begin
                        rem = rem << 1;
                        t = t << 1;
                        if (rem >= s)
                        begin
                            rem = rem - s;
                            t[0] = 1'b1;
                        end
                    end
                end
                for (int i = 0; i < 3; i++)
                begin
                    mag = d[i] < 0 ? -d[i] : d[i];
                    m = (mag * t) >> TF;
                    q[i] = d[i] < 0 ? a[i] - longint'(m) : a[i] + longint'(m);
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                r = q[i] - p[i];
                dsq = dsq + r * r;
            end
            root = root_floor(dsq);
            c.near_x = q[0][CW-1:0];
            c.near_y = q[1][CW-1:0];
            c.near_z = q[2][CW-1:0];
            c.dsq = dsq[2*CW+1:0];
            c.droot = root[CW:0];
            pending.push_back(c);
        endfunction

        function void check_result(logic [OUT_W-1:0] w, logic [1:0] u);
            closest_t e;
            closest_t g;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %h", w);
                return;
            end
            e = pending.pop_front();
            g.near_x = w[0 +: CW];
            g.near_y = w[CW +: CW];
            g.near_z = w[2*CW +: CW];
            g.dsq = w[3*CW +: 2*CW+2];
            g.droot = w[5*CW+2 +: CW+1];
            g.region = region_t'(u);
            if (g != e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: exp x=%h y=%h z=%h dsq=%h root=%h reg=%0d,",
                              " got x=%h y=%h z=%h dsq=%h root=%h reg=%0d"},
                             e.near_x, e.near_y, e.near_z, e.dsq, e.droot, e.region,
                             g.near_x, g.near_y, g.near_z, g.dsq, g.droot, g.region);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0]       m_tuser;

    closest_scoreboard board;
    int               cycles;
    bit               quiet_phase;
    bit               hold_off;

    point_segment_closest_distance i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    // Receiver: random stalls, none in the quiet phase, stalled throughout while held off.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= quiet_phase || ($urandom_range(99) >= 10);
    end

    function automatic logic [CW-1:0] coord(int v);
        return CW'(v);
    endfunction

    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(7))
            0: return {1'b1, {(CW-1){1'b0}}};
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return CW'($signed($urandom_range(8192)) - 4096);
            default: return CW'($urandom);
        endcase
    endfunction

    // The valid stays up between words unless an idle cycle is drawn.
    task automatic send_word(logic [IN_W-1:0] w);
        if (!quiet_phase)
            while ($urandom_range(99) < 10)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tdata <= w;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_segment(w);
        @(negedge clk);
    endtask

    task automatic send_points(logic [CW-1:0] ax, ay, az, bx, by, bz, px, py, pz);
        send_word(IN_W'({pz, py, px, bz, by, bx, az, ay, ax}));
    endtask

    task automatic send_random();
        logic [CW-1:0] c[9];
        for (int i = 0; i < 9; i++)
            c[i] = pick_coord();
        // Some degenerate segments and some short segments.
        if ($urandom_range(9) == 0)
            for (int i = 0; i < 3; i++)
                c[3+i] = c[i];
        else if ($urandom_range(9) == 0)
            for (int i = 0; i < 3; i++)
                c[3+i] = c[i] + CW'($signed($urandom_range(4)) - 2);
        send_points(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [CW-1:0] mx;
        logic [CW-1:0] mn;
        logic [CW-1:0] z;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        z = '0;
        board = new();
        cycles = 0;
        quiet_phase = 0;
        hold_off = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Degenerate segments, clamps on both ends, exact ends, extremes.
        send_points(z, z, z, z, z, z, z, z, z);
        send_points(mx, mx, mx, mx, mx, mx, mn, mn, mn);
        send_points(mn, mn, mn, mn, mn, mn, mx, mx, mx);
        send_points(z, z, z, coord(4096), z, z, coord(-4096), coord(5), z);
        send_points(z, z, z, coord(4096), z, z, coord(9000), z, coord(-7));
        send_points(z, z, z, coord(4096), z, z, z, coord(300), z);
        send_points(z, z, z, coord(4096), z, z, coord(4096), z, coord(300));
        send_points(z, z, z, coord(4096), coord(4096), z,
                    coord(1000), coord(3000), coord(5));
        send_points(mn, mn, mn, mx, mx, mx, z, z, z);
        send_points(mx, mn, mx, mn, mx, mn, mx, mx, mx);
        send_points(mn, mn, mn, mx, mx, mx, mx, mx, mx);
        send_points(mn, mx, z, mx, mn, z, mn, mn, mn);
        send_points(coord(1), coord(2), coord(3), coord(4), coord(7), coord(9),
                    coord(2), coord(5), coord(6));
        send_points(coord(-3), z, z, coord(3), z, z, coord(1), coord(100), coord(-100));
        wait_drained();

        // Back-pressure: receiver held off while the sender keeps offering.
        fork
            begin
                hold_off = 1;
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            repeat (120) send_random();
        join
        wait_drained();

        quiet_phase = 1;
        repeat (200) send_random();
        quiet_phase = 0;
        repeat (680) send_random();

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
src/psd_pkg.sv
src/psd_front.sv
src/psd_div.sv
src/psd_back.sv
src/psd_sqrt.sv
src/point_segment_closest_distance.sv
bench/tb_point_segment_closest_distance.sv
